@@ rtl/ttyld_pkg.sv @@
// ----------------------------------------------------------------------------
// ttyld_pkg
// Shared constants, codes and types of the terminal line discipline.
// ----------------------------------------------------------------------------
`default_nettype none

package ttyld_pkg;

    // sizing defaults
    localparam int LINE_MAX_DEF     = 256;
    localparam int TAB_WIDTH_DEF    = 8;
    localparam int ERASE_TAB_REPEAT = 8;
    localparam int MAX_RESULTS      = 24;
    localparam int REP_W            = $clog2(ERASE_TAB_REPEAT + 1);
    localparam int TOT_W            = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int BYTE_W = 8;
    localparam int DEST_W = 2;
    localparam int CFG_W  = 9;
    localparam int IDX_W  = 3;
    localparam int RL_W   = 9;

    // character constants
    localparam logic [BYTE_W-1:0] CH_NL  = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    // command codes
    localparam logic CMD_RX = 1'b0;
    localparam logic CMD_TX = 1'b1;

    // result destinations
    localparam logic [DEST_W-1:0] DEST_READER = 2'd0;
    localparam logic [DEST_W-1:0] DEST_TX     = 2'd1;
    localparam logic [DEST_W-1:0] DEST_EOF    = 2'd2;
    localparam logic [DEST_W-1:0] DEST_RSVD   = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_INPUT_FLAGS  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_OUTPUT_FLAGS = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ERASE        = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ERASE_ALT    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_EOF          = 3'd4;
    localparam logic [IDX_W-1:0] CFG_EOL          = 3'd5;
    localparam logic [IDX_W-1:0] CFG_READ_LENGTH  = 3'd6;

    // register reset values
    localparam logic [4:0]        RST_IFLAGS    = 5'd15;
    localparam logic [2:0]        RST_OFLAGS    = 3'd3;
    localparam logic [BYTE_W-1:0] RST_ERASE     = 8'd8;
    localparam logic [BYTE_W-1:0] RST_ERASE_ALT = 8'd127;
    localparam logic [BYTE_W-1:0] RST_EOF       = 8'd4;
    localparam logic [BYTE_W-1:0] RST_EOL       = 8'd0;
    localparam logic [RL_W-1:0]   RST_RL        = 9'd256;

    // echo / transmit unit shapes
    localparam logic [2:0] UNIT_NONE  = 3'd0;
    localparam logic [2:0] UNIT_PLAIN = 3'd1;
    localparam logic [2:0] UNIT_CRNL  = 3'd2;
    localparam logic [2:0] UNIT_VIS   = 3'd3;
    localparam logic [2:0] UNIT_TABS  = 3'd4;

    // unit repeat source
    localparam logic [1:0] REPS_NONE = 2'd0;
    localparam logic [1:0] REPS_ONE  = 2'd1;
    localparam logic [1:0] REPS_MARK = 2'd2;

    typedef struct packed {
        logic              head;      // a reader byte or EOF marker goes first
        logic [DEST_W-1:0] head_dest;
        logic              head_end;
        logic [BYTE_W-1:0] ch;
        logic [2:0]        unit;
        logic [1:0]        reps;
    } t_job;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [BYTE_W-1:0] data;
        logic              eor;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/ttyld_in_if.sv @@
// ----------------------------------------------------------------------------
// ttyld_in_if
// Input channel: command and byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttyld_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/ttyld_out_if.sv @@
// ----------------------------------------------------------------------------
// ttyld_out_if
// Result channel: destination, byte, end of read and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttyld_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] destination;
    logic [7:0] out_byte;
    logic       end_of_read;
    logic       last;

    modport source (output valid, output destination, output out_byte,
                    output end_of_read, output last, input ready);
    modport sink   (input valid, input destination, input out_byte,
                    input end_of_read, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/tty_line_discipline.sv @@
// ----------------------------------------------------------------------------
// tty_line_discipline
// Canonical terminal line discipline: CR mapping, erase/EOF/EOL editing,
// echo and output processing (NL to CR NL, tab expansion).
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Carries
//  i_in      in   valid/ready        command, in_byte
//  o_out     out  valid/ready        destination, out_byte, end_of_read, last
//  i_cfg_*   in   write enable only  register index, write data (9 bits)
//
//  An accepted transaction is registered in the decode stage (tab-mark
//  read or write, line count update), then the result sequencer puts out
//  its N results (0 to 24). The sequencer, which puts out one result per
//  cycle while o_out is not stalled, sets the sustained rate.
//  Reset is synchronous, active low; it restores the registers and clears the
//  line count. Tab marks need no clearing: only positions written in the
//  current read are ever read back.
//  A stalled o_out holds its result; the sequencer and decode stage back up
//  behind it and i_in.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module tty_line_discipline import ttyld_pkg::*; #(
    parameter int LINE_MAX  = LINE_MAX_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    ttyld_in_if.sink              i_in,
    ttyld_out_if.source           o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

    // decode stage -> sequencer
    logic          job_valid;
    t_job          job;
    logic          take;

    // tab-mark RAM: one bit per position of the current read
    logic          mark_we, mark_wdata, mark_re, mark_rdata;
    logic [AW-1:0] mark_waddr, mark_raddr;

    ttyld_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_take       (take),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .o_mark_we    (mark_we),
        .o_mark_waddr (mark_waddr),
        .o_mark_wdata (mark_wdata),
        .o_mark_re    (mark_re),
        .o_mark_raddr (mark_raddr)
    );

    // read data stays put until the next erase is accepted, which cannot
    // happen before the sequencer has taken the current job
    ttyld_ram #(
        .WIDTH (1),
        .DEPTH (LINE_MAX)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_re    (mark_re),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    ttyld_emit #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_mark      (mark_rdata),
        .o_take      (take),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/ttyld_ram.sv @@
// ----------------------------------------------------------------------------
// ttyld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyld_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/ttyld_front.sv @@
// ----------------------------------------------------------------------------
// ttyld_front
// Register file, input decode, line count and tab-mark RAM access.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyld_front import ttyld_pkg::*; #(
    parameter  int LINE_MAX = LINE_MAX_DEF,
    localparam int CW       = $clog2(LINE_MAX + 1),
    localparam int AW       = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ttyld_in_if.sink               i_in,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_take,
    output      logic              o_job_valid,
    output      t_job              o_job,
    output      logic              o_mark_we,
    output      logic [AW-1:0]     o_mark_waddr,
    output      logic              o_mark_wdata,
    output      logic              o_mark_re,
    output      logic [AW-1:0]     o_mark_raddr
);

    localparam int LW = ((CW > RL_W) ? CW : RL_W);

    logic [4:0]        r_iflags;
    logic [2:0]        r_oflags;
    logic [BYTE_W-1:0] r_erase, r_erase_alt, r_eof, r_eol;
    logic [RL_W-1:0]   r_rl;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_s1_valid;
    t_job              r_s1_job, n_job;

    logic              accept;
    logic [BYTE_W-1:0] ch_rx;
    logic              canon, is_erase, is_eof, is_deliver;
    logic [CW-1:0]     cnt_inc, cnt_dec;
    logic [RL_W-1:0]   rl_eff;
    logic              full, line_end;
    logic [2:0]        tx_unit_raw, tx_unit_rx, echo_unit;
    logic              echo_en, visual;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iflags    <= RST_IFLAGS;
            r_oflags    <= RST_OFLAGS;
            r_erase     <= RST_ERASE;
            r_erase_alt <= RST_ERASE_ALT;
            r_eof       <= RST_EOF;
            r_eol       <= RST_EOL;
            r_rl        <= RST_RL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INPUT_FLAGS:  r_iflags    <= i_cfg_data[4:0];
                CFG_OUTPUT_FLAGS: r_oflags    <= i_cfg_data[2:0];
                CFG_ERASE:        r_erase     <= i_cfg_data[BYTE_W-1:0];
                CFG_ERASE_ALT:    r_erase_alt <= i_cfg_data[BYTE_W-1:0];
                CFG_EOF:          r_eof       <= i_cfg_data[BYTE_W-1:0];
                CFG_EOL:          r_eol       <= i_cfg_data[BYTE_W-1:0];
                CFG_READ_LENGTH:  r_rl        <= i_cfg_data[RL_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_s1_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    // decode
    always_comb begin
        ch_rx      = (r_iflags[0] && i_in.in_byte == CH_CR) ? CH_NL : i_in.in_byte;
        canon      = r_iflags[1];
        is_erase   = canon && (ch_rx == r_erase || ch_rx == r_erase_alt);
        is_eof     = canon && !is_erase && ch_rx == r_eof;
        is_deliver = !is_erase && !is_eof;
        cnt_inc    = r_cnt + 1'b1;
        cnt_dec    = r_cnt - 1'b1;
        rl_eff     = (r_rl == '0) ? RL_W'(1) : r_rl;
        full       = (LW'(cnt_inc) >= LW'(rl_eff)) || (cnt_inc >= CW'(LINE_MAX));
        line_end   = full || (canon && (ch_rx == CH_NL || ch_rx == r_eol));
    end

    // transmit shapes of the raw byte (program output) and the mapped byte
    always_comb begin
        tx_unit_raw = UNIT_PLAIN;
        if (r_oflags[0] && r_oflags[1] && i_in.in_byte == CH_NL) begin
            tx_unit_raw = UNIT_CRNL;
        end else if (r_oflags[0] && r_oflags[2] && i_in.in_byte == CH_TAB) begin
            tx_unit_raw = UNIT_TABS;
        end
        tx_unit_rx = UNIT_PLAIN;
        if (r_oflags[0] && r_oflags[1] && ch_rx == CH_NL) begin
            tx_unit_rx = UNIT_CRNL;
        end else if (r_oflags[0] && r_oflags[2] && ch_rx == CH_TAB) begin
            tx_unit_rx = UNIT_TABS;
        end
        echo_en = r_iflags[2] || (r_iflags[4] && ch_rx == CH_NL);
        visual  = r_iflags[3] && (ch_rx == r_erase || ch_rx == r_erase_alt);
        if (!echo_en) begin
            echo_unit = UNIT_NONE;
        end else if (visual) begin
            echo_unit = UNIT_VIS;
        end else begin
            echo_unit = tx_unit_rx;
        end
    end

    // job and line count
    always_comb begin
        n_cnt          = r_cnt;
        n_job.head      = 1'b0;
        n_job.head_dest = DEST_READER;
        n_job.head_end  = 1'b0;
        n_job.ch        = ch_rx;
        n_job.unit      = echo_unit;
        n_job.reps      = REPS_ONE;
        if (i_in.command == CMD_TX) begin
            n_job.ch   = i_in.in_byte;
            n_job.unit = tx_unit_raw;
        end else if (is_erase) begin
            n_job.reps = (r_cnt != '0) ? REPS_MARK : REPS_NONE;
            if (r_cnt != '0) begin
                n_cnt = cnt_dec;
            end
        end else if (is_eof) begin
            n_job.head      = 1'b1;
            n_job.head_dest = DEST_EOF;
            n_job.head_end  = 1'b1;
            n_job.ch        = CH_NUL;
            n_job.unit      = UNIT_NONE;
            n_job.reps      = REPS_NONE;
            n_cnt           = '0;
        end else begin
            n_job.head     = 1'b1;
            n_job.head_end = line_end;
            n_cnt          = line_end ? '0 : cnt_inc;
        end
    end

    // at most one access per accepted transaction: no same-edge read/write clash
    assign o_mark_we    = accept && i_in.command == CMD_RX && is_deliver;
    assign o_mark_waddr = r_cnt[AW-1:0];
    assign o_mark_wdata = (ch_rx == CH_TAB);
    assign o_mark_re    = accept && i_in.command == CMD_RX && is_erase && r_cnt != '0;
    assign o_mark_raddr = cnt_dec[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept && i_in.command == CMD_RX) begin
                r_cnt <= n_cnt;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_job <= n_job;
        end
    end

    assign o_job_valid = r_s1_valid;
    assign o_job       = r_s1_job;

endmodule

`default_nettype wire

@@ rtl/ttyld_emit.sv @@
// ----------------------------------------------------------------------------
// ttyld_emit
// Result sequencer: head item, echo units with repeats, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyld_emit import ttyld_pkg::*; #(
    parameter  int TAB_WIDTH = TAB_WIDTH_DEF,
    localparam int UNIT_MAX  = (TAB_WIDTH > 3) ? TAB_WIDTH : 3,
    localparam int PW        = $clog2(UNIT_MAX + 1)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_job_valid,
    input  wire t_job  i_job,
    input  wire logic  i_mark,
    output      logic  o_take,
    ttyld_out_if.source o_out
);

    logic             r_busy;
    logic             r_head;
    logic [REP_W-1:0] r_reps;
    logic [PW-1:0]    r_pos;
    logic [TOT_W-1:0] r_total;
    t_job             r_job;
    logic             r_ovalid;
    t_result          r_out;

    logic             adv, seq_more, more_in_unit, next_exists, job_has;
    logic [PW-1:0]    cur_len, new_len, pos_inc;
    logic [REP_W-1:0] new_reps;
    t_result          item;

    function automatic logic [PW-1:0] unit_len(input logic [2:0] u);
        logic [PW-1:0] n;
        unique case (u)
            UNIT_NONE:  n = PW'(0);
            UNIT_PLAIN: n = PW'(1);
            UNIT_CRNL:  n = PW'(2);
            UNIT_VIS:   n = PW'(3);
            UNIT_TABS:  n = PW'(TAB_WIDTH);
            default:    n = PW'(0);
        endcase
        return n;
    endfunction

    always_comb begin
        cur_len      = unit_len(r_job.unit);
        pos_inc      = r_pos + 1'b1;
        more_in_unit = pos_inc < cur_len;
        seq_more     = r_head ? (r_reps != '0 && cur_len != '0)
                              : (more_in_unit || r_reps > REP_W'(1));
        next_exists  = seq_more && (r_total < TOT_W'(MAX_RESULTS - 1));
        adv          = r_busy && (!r_ovalid || o_out.ready);
        o_take       = i_job_valid && (!r_busy || (adv && !next_exists));

        unique case (i_job.reps)
            REPS_NONE: new_reps = '0;
            REPS_ONE:  new_reps = REP_W'(1);
            REPS_MARK: new_reps = i_mark ? REP_W'(ERASE_TAB_REPEAT) : REP_W'(1);
            default:   new_reps = '0;
        endcase
        new_len = unit_len(i_job.unit);
        job_has = i_job.head || (new_reps != '0 && new_len != '0);
    end

    // current result
    always_comb begin
        item.last = !next_exists;
        if (r_head) begin
            item.dest = r_job.head_dest;
            item.data = r_job.ch;
            item.eor  = r_job.head_end;
        end else begin
            item.dest = DEST_TX;
            item.eor  = 1'b0;
            case (r_job.unit)
                UNIT_VIS:  item.data = (r_pos == PW'(1)) ? CH_SP : CH_BS;
                UNIT_CRNL: item.data = (r_pos == '0) ? CH_CR : CH_NL;
                UNIT_TABS: item.data = CH_SP;
                default:   item.data = r_job.ch;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy <= job_has;
            end else if (adv) begin
                r_busy <= next_exists;
            end
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= item;
        end
        if (o_take) begin
            r_job   <= i_job;
            r_head  <= i_job.head;
            r_reps  <= new_reps;
            r_pos   <= '0;
            r_total <= '0;
        end else if (adv) begin
            r_total <= r_total + 1'b1;
            if (r_head) begin
                r_head <= 1'b0;
            end else if (more_in_unit) begin
                r_pos <= pos_inc;
            end else begin
                r_pos  <= '0;
                r_reps <= r_reps - 1'b1;
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.destination = r_out.dest;
    assign o_out.out_byte    = r_out.data;
    assign o_out.end_of_read = r_out.eor;
    assign o_out.last        = r_out.last;

endmodule

`default_nettype wire

@@ rtl/ttyld_checker.sv @@
// ----------------------------------------------------------------------------
// ttyld_checker
// Port-level checks of the line discipline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyld_checker import ttyld_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [DEST_W-1:0] i_out_dest,
    input wire logic [BYTE_W-1:0] i_out_byte,
    input wire logic              i_out_end,
    input wire logic              i_out_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_dest)
            && $stable(i_out_end) && $stable(i_out_last))
        else $error("result changed while stalled");

    a_dest_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_dest != DEST_RSVD)
        else $error("reserved destination");

    a_eof_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_dest == DEST_EOF |->
            i_out_end && i_out_last && i_out_byte == CH_NUL)
        else $error("malformed end of file marker");

    a_tx_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_dest == DEST_TX |-> !i_out_end)
        else $error("transmitter byte flagged end of read");

endmodule

bind tty_line_discipline ttyld_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_dest  (o_out.destination),
    .i_out_byte  (o_out.out_byte),
    .i_out_end   (o_out.end_of_read),
    .i_out_last  (o_out.last)
);

`default_nettype wire
